/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SDV_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sdv assertion failed");

// Checked at every edge, reset included.
`define SDV_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sdv assertion failed");

`endif

/* hdl/sdv_pkg.sv */
// Shared types, constants and helpers of the smooth damp block.
package sdv_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DT_BITS       = 16;
  localparam int VW            = 32;
  localparam int CFG_W         = 31;
  localparam int MUL_W         = 34;
  localparam int PROD_W        = 2 * MUL_W;
  localparam int DIV_W         = 64;
  localparam int DEN_W         = 33;
  localparam int DACC_W        = 34;
  localparam int ROOT_W        = 33;
  localparam int IDX_W         = 2;
  localparam int AXES          = 3;

  localparam logic [IDX_W-1:0] REG_SMOOTH_TIME = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_MAX_SPEED   = IDX_W'(1);

  localparam logic [CFG_W-1:0] SMOOTH_TIME_RST = CFG_W'(19661);
  localparam logic [CFG_W-1:0] MAX_SPEED_RST   = '1;

  typedef logic signed [VW-1:0]     q_t;
  typedef logic signed [MUL_W-1:0]  mop_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam prod_t Q_MAX = prod_t'(64'sd2147483647);
  localparam prod_t Q_MIN = -Q_MAX - prod_t'(1);

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  val;
  } sqrt_req_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_OMEGA_GO, ST_OMEGA_WT,
    ST_X, ST_XS, ST_X2, ST_X2S, ST_X3, ST_X3S,
    ST_K1, ST_K1S, ST_K2, ST_K2S, ST_DEC_GO, ST_DEC_WT,
    ST_LIM, ST_LIMS, ST_LL, ST_LLS, ST_SQ, ST_SQS, ST_CMP,
    ST_SQRT_GO, ST_SQRT_WT, ST_QM, ST_QD_GO, ST_QD_WT,
    ST_A1, ST_A1S, ST_A2, ST_A2S, ST_A3, ST_A3S, ST_A4, ST_A4S, ST_A5, ST_A5S,
    ST_DOT, ST_DOTS, ST_FIN
  } sdv_state_t;

  function automatic q_t sat32(input prod_t v);
    q_t res;
    if (v > Q_MAX) begin
      res = q_t'(Q_MAX[VW-1:0]);
    end else if (v < Q_MIN) begin
      res = q_t'(Q_MIN[VW-1:0]);
    end else begin
      res = q_t'(v[VW-1:0]);
    end
    return res;
  endfunction

endpackage

/* hdl/sdv_mul.sv */
// Shared signed multiplier with registered product.
module sdv_mul (
  input  logic          clk,
  input  sdv_pkg::mop_t mul_a,
  input  sdv_pkg::mop_t mul_b,
  output sdv_pkg::prod_t prod_r
);
  import sdv_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= prod_t'(mul_a) * prod_t'(mul_b);
  end

endmodule

/* hdl/sdv_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module sdv_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sdv_pkg::div_req_t         req,
  output logic                      busy,
  output logic [sdv_pkg::DIV_W-1:0] quot
);
  import sdv_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt, den_r;
  logic [DEN_W:0]   rem_sh;
  logic             qbit;

  always_comb begin
    rem_sh = {rem_r, num_r[DIV_W-1]};
    qbit   = (rem_sh >= {1'b0, den_r});
    if (qbit) begin
      rem_nxt = DEN_W'(rem_sh - {1'b0, den_r});
    end else begin
      rem_nxt = rem_sh[DEN_W-1:0];
    end
    num_nxt = {num_r[DIV_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DIV_W - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign quot = num_r;

endmodule

/* hdl/sdv_sqrt.sv */
// Floor integer square root of a 64-bit value, one root bit per cycle.
module sdv_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sdv_pkg::sqrt_req_t         req,
  output logic                       busy,
  output logic [sdv_pkg::ROOT_W-1:0] root
);
  import sdv_pkg::*;

  localparam int STEPS = DIV_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] n_r, r_r, bit_r, trial;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(STEPS - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      n_r   <= req.val;
      r_r   <= '0;
      bit_r <= DIV_W'(1) << (DIV_W - 2);
    end else if (busy_r) begin
      if (n_r >= trial) begin
        n_r <= n_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign busy = busy_r;
  assign root = r_r[ROOT_W-1:0];

endmodule

/* hdl/smooth_damp_vector_top.sv */
// Top level: sequencer and datapath of the 3D critically damped smooth follow.
//
//   channel  | handshake         | payload
//   ---------+-------------------+-----------------------------------------
//   in       | in_valid/in_stall | cur_x..z, goal_x..z, time_step
//   out      | out_valid/out_stall | new_x..z, speed_x..z
//   cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// The divider (omega, decay and three rescales) and the square root set the
// length of a beat, with the shared multiply steps between them; the square
// root and the rescales run only when the offset is clamped.
// rst_n is synchronous; it clears velocity, the config registers, out_valid and the sequencer.
// in_stall is high while an item is at work; a finished result waits in the
// output register and the next item is taken meanwhile.
module smooth_damp_vector_top #(
  parameter int FRAC_BITS = sdv_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  sdv_pkg::q_t                 cur_x,
  input  sdv_pkg::q_t                 cur_y,
  input  sdv_pkg::q_t                 cur_z,
  input  sdv_pkg::q_t                 goal_x,
  input  sdv_pkg::q_t                 goal_y,
  input  sdv_pkg::q_t                 goal_z,
  input  logic [sdv_pkg::DT_BITS-1:0] time_step,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sdv_pkg::q_t                 new_x,
  output sdv_pkg::q_t                 new_y,
  output sdv_pkg::q_t                 new_z,
  output sdv_pkg::q_t                 speed_x,
  output sdv_pkg::q_t                 speed_y,
  output sdv_pkg::q_t                 speed_z,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sdv_pkg::IDX_W-1:0]   cfg_index,
  input  logic [sdv_pkg::VW-1:0]      cfg_data
);
  import sdv_pkg::*;

  localparam logic [DIV_W-1:0]  OMEGA_NUM  = DIV_W'(2) << (2 * FRAC_BITS);
  localparam logic [DIV_W-1:0]  DECAY_NUM  = DIV_W'(1) << (2 * FRAC_BITS);
  localparam logic [CFG_W-1:0]  SMOOTH_MIN =
    CFG_W'(((64'd1 << FRAC_BITS) + 64'd9999) / 64'd10000);
  localparam mop_t              K_048  = mop_t'(((64'd48 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam mop_t              K_0235 =
    mop_t'(((64'd235 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [DACC_W-1:0] ONE_Q    = DACC_W'(1) << FRAC_BITS;
  localparam logic [1:0]        LAST_AX  = 2'(AXES - 1);

  sdv_state_t state_r, state_nxt;

  logic [CFG_W-1:0]   smooth_r, maxsp_r, st;
  logic [1:0]         i_r;
  q_t                 cur_r [AXES];
  q_t                 goal_r [AXES];
  q_t                 d_r [AXES];
  q_t                 vel_r [AXES];
  q_t                 pos_r [AXES];
  q_t                 vn_r [AXES];
  logic [DT_BITS-1:0] dt_r;
  q_t                 omega_r, x_r, x2_r, x3_r, decay_r, s_r, tmp_r, w_r, u_r;
  logic [DACC_W-1:0]  den_r, den_sat;
  logic [CFG_W-1:0]   lim_r;
  logic [61:0]        ll_r;
  logic [DIV_W-1:0]   len2_r;
  logic [ROOT_W-1:0]  len_r;
  prod_t              dot_r;
  logic               out_valid_r, out_load;
  q_t                 out_pos_r [AXES];
  q_t                 out_vel_r [AXES];

  mop_t               mul_a, mul_b;
  prod_t              prod_r;
  div_req_t           div_req;
  sqrt_req_t          sqrt_req;
  logic               div_busy, sqrt_busy;
  logic [DIV_W-1:0]   div_quot;
  logic [ROOT_W-1:0]  sqrt_root;

  q_t                 mulq_v, asr16_v, d_i, cur_i, goal_i, q_v;
  logic [VW-1:0]      mag_i;
  logic signed [VW:0] a_i, b_i;
  prod_t              lim_pre;

  sdv_mul u_mul (.clk(clk), .mul_a(mul_a), .mul_b(mul_b), .prod_r(prod_r));

  sdv_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .busy(div_busy),
                 .quot(div_quot));

  sdv_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sqrt_req), .busy(sqrt_busy),
                   .root(sqrt_root));

  assign st      = (smooth_r < SMOOTH_MIN) ? SMOOTH_MIN : smooth_r;
  assign mulq_v  = sat32(prod_r >>> FRAC_BITS);
  assign asr16_v = sat32(prod_r >>> DT_BITS);
  assign d_i     = d_r[i_r];
  assign cur_i   = cur_r[i_r];
  assign goal_i  = goal_r[i_r];
  assign mag_i   = d_i[VW-1] ? VW'(-d_i) : VW'(d_i);
  assign a_i     = {goal_i[VW-1], goal_i} - {cur_i[VW-1], cur_i};
  assign b_i     = {pos_r[i_r][VW-1], pos_r[i_r]} - {goal_i[VW-1], goal_i};
  assign lim_pre = prod_r >>> FRAC_BITS;
  assign den_sat = (den_r > DACC_W'(Q_MAX)) ? DACC_W'(Q_MAX) : den_r;
  assign q_v     = q_t'(div_quot[VW-1:0]);
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_OMEGA_GO;
      ST_OMEGA_GO: state_nxt = ST_OMEGA_WT;
      ST_OMEGA_WT: if (!div_busy) state_nxt = ST_X;
      ST_X:        state_nxt = ST_XS;
      ST_XS:       state_nxt = ST_X2;
      ST_X2:       state_nxt = ST_X2S;
      ST_X2S:      state_nxt = ST_X3;
      ST_X3:       state_nxt = ST_X3S;
      ST_X3S:      state_nxt = ST_K1;
      ST_K1:       state_nxt = ST_K1S;
      ST_K1S:      state_nxt = ST_K2;
      ST_K2:       state_nxt = ST_K2S;
      ST_K2S:      state_nxt = ST_DEC_GO;
      ST_DEC_GO:   state_nxt = ST_DEC_WT;
      ST_DEC_WT: begin
        if (!div_busy) state_nxt = (maxsp_r == MAX_SPEED_RST) ? ST_A1 : ST_LIM;
      end
      ST_LIM:      state_nxt = ST_LIMS;
      ST_LIMS:     state_nxt = ST_LL;
      ST_LL:       state_nxt = ST_LLS;
      ST_LLS:      state_nxt = ST_SQ;
      ST_SQ:       state_nxt = ST_SQS;
      ST_SQS:      state_nxt = (i_r == LAST_AX) ? ST_CMP : ST_SQ;
      ST_CMP:      state_nxt = (len2_r > {2'b0, ll_r}) ? ST_SQRT_GO : ST_A1;
      ST_SQRT_GO:  state_nxt = ST_SQRT_WT;
      ST_SQRT_WT:  if (!sqrt_busy) state_nxt = ST_QM;
      ST_QM:       state_nxt = ST_QD_GO;
      ST_QD_GO:    state_nxt = ST_QD_WT;
      ST_QD_WT: begin
        if (!div_busy) state_nxt = (i_r == LAST_AX) ? ST_A1 : ST_QM;
      end
      ST_A1:       state_nxt = ST_A1S;
      ST_A1S:      state_nxt = ST_A2;
      ST_A2:       state_nxt = ST_A2S;
      ST_A2S:      state_nxt = ST_A3;
      ST_A3:       state_nxt = ST_A3S;
      ST_A3S:      state_nxt = ST_A4;
      ST_A4:       state_nxt = ST_A4S;
      ST_A4S:      state_nxt = ST_A5;
      ST_A5:       state_nxt = ST_A5S;
      ST_A5S:      state_nxt = (i_r == LAST_AX) ? ST_DOT : ST_A1;
      ST_DOT:      state_nxt = ST_DOTS;
      ST_DOTS:     state_nxt = (i_r == LAST_AX) ? ST_FIN : ST_DOT;
      ST_FIN:      if (out_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // unit operands per state
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    div_req  = '0;
    sqrt_req = '0;
    unique case (state_r)
      ST_OMEGA_GO: begin
        div_req.start = 1'b1;
        div_req.num   = OMEGA_NUM;
        div_req.den   = DEN_W'(st);
      end
      ST_X:  begin mul_a = mop_t'(omega_r); mul_b = $signed({18'b0, dt_r}); end
      ST_X2: begin mul_a = mop_t'(x_r);     mul_b = mop_t'(x_r);  end
      ST_X3: begin mul_a = mop_t'(x2_r);    mul_b = mop_t'(x_r);  end
      ST_K1: begin mul_a = K_048;           mul_b = mop_t'(x2_r); end
      ST_K2: begin mul_a = K_0235;          mul_b = mop_t'(x3_r); end
      ST_DEC_GO: begin
        div_req.start = 1'b1;
        div_req.num   = DECAY_NUM;
        div_req.den   = DEN_W'(den_sat);
      end
      ST_LIM: begin mul_a = $signed({3'b0, maxsp_r}); mul_b = $signed({3'b0, st}); end
      ST_LL:  begin mul_a = $signed({3'b0, lim_r});   mul_b = $signed({3'b0, lim_r}); end
      ST_SQ:  begin mul_a = $signed({2'b0, mag_i});   mul_b = $signed({2'b0, mag_i}); end
      ST_SQRT_GO: begin
        sqrt_req.start = 1'b1;
        sqrt_req.val   = len2_r;
      end
      ST_QM:  begin mul_a = $signed({2'b0, mag_i});   mul_b = $signed({3'b0, lim_r}); end
      ST_QD_GO: begin
        div_req.start = 1'b1;
        div_req.num   = prod_r[DIV_W-1:0];
        div_req.den   = len_r;
      end
      ST_A1: begin mul_a = mop_t'(omega_r); mul_b = mop_t'(d_i); end
      ST_A2: begin mul_a = mop_t'(s_r);     mul_b = $signed({18'b0, dt_r}); end
      ST_A3: begin mul_a = mop_t'(omega_r); mul_b = mop_t'(tmp_r); end
      ST_A4: begin mul_a = mop_t'(w_r);     mul_b = mop_t'(decay_r); end
      ST_A5: begin mul_a = mop_t'(u_r);     mul_b = mop_t'(decay_r); end
      ST_DOT: begin mul_a = mop_t'(a_i);    mul_b = mop_t'(b_i); end
      default: begin end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      smooth_r    <= SMOOTH_TIME_RST;
      maxsp_r     <= MAX_SPEED_RST;
      out_valid_r <= 1'b0;
      for (int k = 0; k < AXES; k++) vel_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        priority if (cfg_index == REG_SMOOTH_TIME) begin
          smooth_r <= cfg_data[CFG_W-1:0];
        end else if (cfg_index == REG_MAX_SPEED) begin
          maxsp_r <= cfg_data[CFG_W-1:0];
        end
      end
      if ((state_r == ST_SQS) || (state_r == ST_A5S) || (state_r == ST_DOTS) ||
          ((state_r == ST_QD_WT) && !div_busy)) begin
        i_r <= (i_r == LAST_AX) ? 2'd0 : i_r + 2'd1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      // overshoot: the exact dot product says the goal was passed
      if (out_load) begin
        for (int k = 0; k < AXES; k++) vel_r[k] <= (dot_r > prod_t'(0)) ? '0 : vn_r[k];
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cur_r[0]  <= cur_x;  cur_r[1]  <= cur_y;  cur_r[2]  <= cur_z;
          goal_r[0] <= goal_x; goal_r[1] <= goal_y; goal_r[2] <= goal_z;
          d_r[0] <= sat32(prod_t'(cur_x) - prod_t'(goal_x));
          d_r[1] <= sat32(prod_t'(cur_y) - prod_t'(goal_y));
          d_r[2] <= sat32(prod_t'(cur_z) - prod_t'(goal_z));
          dt_r   <= time_step;
        end
      end
      ST_OMEGA_GO: begin
        len2_r <= '0;
        dot_r  <= '0;
      end
      ST_OMEGA_WT: begin
        if (!div_busy) begin
          omega_r <= (div_quot > DIV_W'(Q_MAX)) ? q_t'(Q_MAX[VW-1:0]) : q_v;
        end
      end
      ST_XS: begin
        x_r   <= asr16_v;
        den_r <= ONE_Q + DACC_W'(asr16_v);
      end
      ST_X2S: x2_r <= mulq_v;
      ST_X3S: x3_r <= mulq_v;
      ST_K1S, ST_K2S: den_r <= den_r + DACC_W'(mulq_v);
      ST_DEC_WT: if (!div_busy) decay_r <= q_v;
      ST_LIMS: lim_r <= (lim_pre > Q_MAX) ? CFG_W'(Q_MAX) : lim_pre[CFG_W-1:0];
      ST_LLS:  ll_r  <= prod_r[61:0];
      ST_SQS:  len2_r <= len2_r + prod_r[DIV_W-1:0];
      ST_SQRT_WT: if (!sqrt_busy) len_r <= sqrt_root;
      ST_QD_WT: begin
        if (!div_busy) d_r[i_r] <= d_i[VW-1] ? -q_v : q_v;
      end
      ST_A1S: s_r   <= sat32(prod_t'(vel_r[i_r]) + prod_t'(mulq_v));
      ST_A2S: tmp_r <= asr16_v;
      ST_A3S: begin
        w_r <= sat32(prod_t'(vel_r[i_r]) - prod_t'(mulq_v));
        u_r <= sat32(prod_t'(d_i) + prod_t'(tmp_r));
      end
      ST_A4S: vn_r[i_r] <= mulq_v;
      ST_A5S: begin
        pos_r[i_r] <= sat32(prod_t'(sat32(prod_t'(cur_i) - prod_t'(d_i))) +
                            prod_t'(mulq_v));
      end
      ST_DOTS: dot_r <= dot_r + prod_r;
      ST_FIN: begin
        if (out_load) begin
          for (int k = 0; k < AXES; k++) begin
            out_pos_r[k] <= (dot_r > prod_t'(0)) ? goal_r[k] : pos_r[k];
            out_vel_r[k] <= (dot_r > prod_t'(0)) ? '0 : vn_r[k];
          end
        end
      end
      default: begin end
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign new_x     = out_pos_r[0];
  assign new_y     = out_pos_r[1];
  assign new_z     = out_pos_r[2];
  assign speed_x   = out_vel_r[0];
  assign speed_y   = out_vel_r[1];
  assign speed_z   = out_vel_r[2];

endmodule

/* hdl/sdv_checker.sv */
// Port-level checks for the smooth damp top, attached by bind.
`include "assert_macros.svh"

module sdv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input sdv_pkg::q_t new_x,
  input sdv_pkg::q_t new_y,
  input sdv_pkg::q_t new_z,
  input sdv_pkg::q_t speed_x,
  input sdv_pkg::q_t speed_y,
  input sdv_pkg::q_t speed_z
);

  logic [6*sdv_pkg::VW-1:0] res_bus;

  assign res_bus = {new_x, new_y, new_z, speed_x, speed_y, speed_z};

  `SDV_ASSERT(out_hold_a, clk, rst_n, out_valid && out_stall |=> out_valid)

  `SDV_ASSERT(out_stable_a, clk, rst_n, out_valid && out_stall |=> $stable(res_bus))

  // a taken beat keeps the sequencer busy on the next cycle
  `SDV_ASSERT(busy_after_take_a, clk, rst_n, in_valid && !in_stall |=> in_stall)

  // a new result only ever comes out of a busy sequencer
  `SDV_ASSERT(result_from_work_a, clk, rst_n, $rose(out_valid) |-> $past(in_stall))

  `SDV_ASSERT_ALWAYS(reset_clean_a, clk, !rst_n |=> !out_valid && !in_stall)

endmodule

bind smooth_damp_vector_top sdv_checker u_sdv_checker (.*);
